@@ rtl/lbps_pkg.sv @@
// Shared types and constants for the LED blink pattern sequencer.
// Used by lbps_cfg_regs, lbps_core and led_blink_pattern_sequencer_unit.
`default_nettype none

package lbps_pkg;

    // Pattern geometry.
    localparam int MAX_STEPS = 4;
    localparam int TIME_REGS = 4;
    localparam int EFF_LIMIT = (MAX_STEPS < TIME_REGS) ? MAX_STEPS : TIME_REGS;

    // Field widths.
    localparam int STEP_TIME_W = 16;
    localparam int STEP_CNT_W  = 3;
    localparam int REPEAT_W    = 16;
    localparam int TICK_MS_W   = 10;
    localparam int TICKS_W     = 17;
    localparam int POS_W       = 2;
    localparam int ELAPSED_W   = TICKS_W + TICK_MS_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;

    localparam logic [TICK_MS_W-1:0] TICK_MS_RESET = TICK_MS_W'(10);
    localparam logic [TICKS_W-1:0]   TICKS_MAX     = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME_0 = 3'd0,
        REG_STEP_TIME_1 = 3'd1,
        REG_STEP_TIME_2 = 3'd2,
        REG_STEP_TIME_3 = 3'd3,
        REG_STEP_COUNT  = 3'd4,
        REG_REPEAT      = 3'd5,
        REG_TICK_MS     = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [TIME_REGS-1:0][STEP_TIME_W-1:0] step_time;
        logic [STEP_CNT_W-1:0]                 step_count;
        logic [TICK_MS_W-1:0]                  tick_ms;
    } t_cfg;

    typedef struct packed {
        logic                load;
        logic [REPEAT_W-1:0] value;
    } t_rep_load;

    typedef struct packed {
        logic running;
        logic finished;
        logic led_on;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/led_blink_pattern_sequencer_unit.sv @@
// Top level of the LED blink pattern sequencer: stream ports, input and output registers.
// Depends on lbps_pkg, lbps_cfg_regs and lbps_core.
`default_nettype none

// How the block is used:
// Each word on the slave stream (i_s_tvalid/o_s_tready/i_s_tdata) is one tick
// of tick_ms milliseconds; bit 0 of the word is the tick flag. For every word
// taken the block returns exactly one word on the master stream
// (o_m_tvalid/i_m_tready/o_m_tdata) carrying the LED level after that tick,
// a one-shot finished flag raised on the tick the repeat count runs out, and
// a running flag that tells whether the pattern is still playing.
// A word accepted is held in the input register, processed by the combinational
// core, and its result is loaded into the output register once that register is
// free. One word can be accepted in every cycle while the receiver keeps up, and
// the pattern state is updated by a single compare against a 17x10 bit product.
// When the receiver stalls, the finished word waits in the output register
// and one further word is held in the input register; after that o_s_tready
// drops until the output register is drained.
// Reset is synchronous and active low. It clears the pattern state, all step
// times, the step count and the remaining repeat count, and sets tick_ms to 10.
// The configuration port is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata);
// the user must write it only while the block is idle, which the block itself does not
// enforce. A write to the repeat register also reloads the remaining repeat count.

module led_blink_pattern_sequencer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Slave stream: bit 0 tick, bits 7:1 zero.
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [lbps_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // Master stream: bit 0 led_on, bit 1 finished, bit 2 running, bits 7:3 zero.
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [lbps_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [lbps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lbps_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lbps_pkg::*;

    t_cfg      cfg;
    t_rep_load rep_load;
    t_result   result;

    logic    r_in_valid;
    logic    r_in_tick;
    logic    r_out_valid;
    t_result r_out;

    logic out_free;
    logic step;
    logic s_accept;

    // The output register is free when empty or being read this cycle.
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign step       = r_in_valid && out_free;

    lbps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_rep_load  (rep_load)
    );

    lbps_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_rep_load (rep_load),
        .i_step     (step),
        .i_tick     (r_in_tick),
        .o_result   (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_tick <= i_s_tdata[0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W-3)'(0), r_out.running, r_out.finished, r_out.led_on};

endmodule

`default_nettype wire

@@ rtl/lbps_cfg_regs.sv @@
// Configuration register file of the LED blink pattern sequencer.
// Depends on lbps_pkg for register indexes and the configuration struct.
`default_nettype none

module lbps_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lbps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lbps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output lbps_pkg::t_cfg                      o_cfg,
    output lbps_pkg::t_rep_load                 o_rep_load
);
    import lbps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_time  <= '0;
            r_cfg.step_count <= '0;
            r_cfg.tick_ms    <= TICK_MS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_STEP_TIME_0: r_cfg.step_time[0] <= i_cfg_wdata[STEP_TIME_W-1:0];
                REG_STEP_TIME_1: r_cfg.step_time[1] <= i_cfg_wdata[STEP_TIME_W-1:0];
                REG_STEP_TIME_2: r_cfg.step_time[2] <= i_cfg_wdata[STEP_TIME_W-1:0];
                REG_STEP_TIME_3: r_cfg.step_time[3] <= i_cfg_wdata[STEP_TIME_W-1:0];
                REG_STEP_COUNT:  r_cfg.step_count   <= i_cfg_wdata[STEP_CNT_W-1:0];
                REG_TICK_MS:     r_cfg.tick_ms      <= i_cfg_wdata[TICK_MS_W-1:0];
                default: ;
            endcase
        end
    end

    // The repeat register is never read back; a write only reloads the
    // remaining count held in the core.
    always_comb begin
        o_rep_load.load  = i_cfg_we && (t_cfg_reg'(i_cfg_idx) == REG_REPEAT);
        o_rep_load.value = i_cfg_wdata[REPEAT_W-1:0];
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/lbps_core.sv @@
// Pattern state and per-tick update of the LED blink pattern sequencer.
// Depends on lbps_pkg for widths, the configuration struct and the result struct.
`default_nettype none

module lbps_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lbps_pkg::t_cfg      i_cfg,
    input  wire lbps_pkg::t_rep_load i_rep_load,
    input  wire logic                i_step,
    input  wire logic                i_tick,
    output lbps_pkg::t_result        o_result
);
    import lbps_pkg::*;

    logic [TICKS_W-1:0]  r_ticks,  n_ticks;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [REPEAT_W-1:0] r_remain, n_remain;
    logic                r_led,    n_led;

    logic [STEP_CNT_W-1:0] eff_steps;
    logic                  active;
    logic [TICKS_W-1:0]    ticks_inc;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [POS_W:0]        pos_inc;
    logic                  fin;

    always_comb begin
        // Step count clipped to the number of steps the pattern supports.
        if (i_cfg.step_count > STEP_CNT_W'(EFF_LIMIT)) begin
            eff_steps = STEP_CNT_W'(EFF_LIMIT);
        end else begin
            eff_steps = i_cfg.step_count;
        end
        active = (r_remain != '0) && (eff_steps != '0);

        ticks_inc = (r_ticks != TICKS_MAX) ? r_ticks + TICKS_W'(1) : r_ticks;
        elapsed   = ELAPSED_W'(ticks_inc) * ELAPSED_W'(i_cfg.tick_ms);
        pos_inc   = {1'b0, r_pos} + (POS_W+1)'(1);

        n_ticks  = r_ticks;
        n_pos    = r_pos;
        n_remain = r_remain;
        n_led    = r_led;
        fin      = 1'b0;

        if (i_tick && active) begin
            if (elapsed <= ELAPSED_W'(i_cfg.step_time[r_pos])) begin
                // Even steps light the LED, odd steps darken it.
                n_ticks = ticks_inc;
                n_led   = ~r_pos[0];
            end else begin
                // Step change: the LED keeps its level.
                n_ticks = '0;
                if (STEP_CNT_W'(pos_inc) >= eff_steps) begin
                    n_pos = '0;
                    if (r_remain != '0 && !r_remain[REPEAT_W-1]) begin
                        n_remain = r_remain - REPEAT_W'(1);
                        fin      = (r_remain == REPEAT_W'(1));
                    end
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end
        end

        o_result.led_on   = n_led;
        o_result.finished = fin;
        o_result.running  = (n_remain != '0) && (eff_steps != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks  <= '0;
            r_pos    <= '0;
            r_remain <= '0;
            r_led    <= 1'b0;
        end else begin
            if (i_step) begin
                r_ticks <= n_ticks;
                r_pos   <= n_pos;
                r_led   <= n_led;
            end
            if (i_rep_load.load) begin
                r_remain <= i_rep_load.value;
            end else if (i_step) begin
                r_remain <= n_remain;
            end
        end
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for led_blink_pattern_sequencer_unit: tick words in, LED status words out.
// Depends on lbps_pkg and the sequencer RTL; a built-in pattern predictor supplies expected words.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbps_pkg::*;

    // Index outside the register file. Writes to it must be dropped. Tick rows
    // of the directed table carry it as a don't-care.
    localparam logic [CFG_IDX_W-1:0] NO_REG = 3'd7;

    localparam int RESET_CYCLES   = 2;
    localparam int RANDOM_PHASES  = 34;
    localparam int WORDS_PER_PHASE = 25;
    localparam int HOLD_CYCLES    = 80;
    localparam int TAIL_CYCLES    = 4;

    // Clock, reset and block inputs, all known from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;

    led_blink_pattern_sequencer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // bit 0 tick, bits 7:1 zero
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // bit 0 led_on, bit 1 finished, bit 2 running, bits 7:3 zero
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the registers and of the pattern state, at reset values.
    t_cfg                pattern_cfg  = '{step_time: '0, step_count: '0, tick_ms: TICK_MS_RESET};
    logic [TICKS_W-1:0]  ticks_in_step = '0;
    logic [POS_W-1:0]    step_pos     = '0;
    logic [REPEAT_W-1:0] repeats_left = '0;
    logic                led_level    = 1'b0;

    // Expected status words, oldest first.
    t_result led_word_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    int mismatches     = 0;
    int words_checked  = 0;
    int finished_seen  = 0;
    int ticks_sent     = 0;
    int idle_ticks     = 0;
    int reg_writes     = 0;

    t_result got_word;
    t_result want_word;

    // Directed table. A write row names a register and its value. A tick row
    // carries the tick flag in bit 0 of the value, and, where the answer is
    // plain, the status word that has to come back.
    typedef enum logic {ROW_WRITE, ROW_TICK} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        t_result               want;
    } t_stim_row;

    t_stim_row directed_rows[] = '{
        // Straight out of reset nothing is configured: idle and dark, with or without a tick.
        '{ROW_TICK,  NO_REG,          16'd1,    1'b1, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd0,    1'b1, 3'b000},
        // Four steps of 1, 1, 2 and 0 ms at 1 ms per tick, a step count above
        // the limit, and a single pass of the pattern.
        '{ROW_WRITE, REG_TICK_MS,     16'd1,    1'b0, 3'b000},
        '{ROW_WRITE, REG_STEP_TIME_0, 16'd1,    1'b0, 3'b000},
        '{ROW_WRITE, REG_STEP_TIME_1, 16'd1,    1'b0, 3'b000},
        '{ROW_WRITE, REG_STEP_TIME_2, 16'd2,    1'b0, 3'b000},
        '{ROW_WRITE, REG_STEP_TIME_3, 16'd0,    1'b0, 3'b000},
        '{ROW_WRITE, REG_STEP_COUNT,  16'd7,    1'b0, 3'b000},
        '{ROW_WRITE, REG_REPEAT,      16'd1,    1'b0, 3'b000},
        // A write past the register file must not land anywhere.
        '{ROW_WRITE, NO_REG,          16'hFFFF, 1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd0,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        // This tick wraps the last step and ends the single pass.
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        // Stopped: the LED keeps its level.
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        // Repeat forever and walk up to the last step.
        '{ROW_WRITE, REG_STEP_TIME_3, 16'd1,    1'b0, 3'b000},
        '{ROW_WRITE, REG_REPEAT,      16'hFFFF, 1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        // Shrink the count under the current position: the last step's time
        // still applies, then the pattern wraps to step 0.
        '{ROW_WRITE, REG_STEP_COUNT,  16'd2,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        // A zero tick length never lets a step run out.
        '{ROW_WRITE, REG_TICK_MS,     16'd0,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000},
        '{ROW_TICK,  NO_REG,          16'd1,    1'b0, 3'b000}
    };

    // Steps in use, clipped to what the block can hold.
    function automatic int unsigned steps_in_use();
        return (pattern_cfg.step_count > EFF_LIMIT) ? EFF_LIMIT : pattern_cfg.step_count;
    endfunction

    function automatic logic pattern_playing();
        return (repeats_left != '0) && (steps_in_use() > 0);
    endfunction

    // Advances the shadow pattern by one tick word and returns the status word
    // that the block must send back for it.
    function automatic t_result advance_pattern(input logic tick_bit);
        int unsigned          next_pos;
        logic [ELAPSED_W-1:0] elapsed_ms;
        t_result              status;
        status.finished = 1'b0;
        if (tick_bit && pattern_playing()) begin
            if (ticks_in_step != TICKS_MAX)
                ticks_in_step = ticks_in_step + 1'b1;
            elapsed_ms = ELAPSED_W'(ticks_in_step) * ELAPSED_W'(pattern_cfg.tick_ms);
            if (elapsed_ms <= ELAPSED_W'(pattern_cfg.step_time[step_pos])) begin
                // Even steps light the LED, odd steps darken it.
                led_level = ~step_pos[0];
            end else begin
                // Step change: the LED keeps its level for this tick.
                ticks_in_step = '0;
                next_pos = step_pos + 1;
                if (next_pos >= steps_in_use()) begin
                    next_pos = 0;
                    // A negative count repeats forever.
                    if (repeats_left != '0 && !repeats_left[REPEAT_W-1]) begin
                        repeats_left = repeats_left - 1'b1;
                        if (repeats_left == '0)
                            status.finished = 1'b1;
                    end
                end
                step_pos = POS_W'(next_pos);
            end
        end
        status.led_on  = led_level;
        status.running = pattern_playing();
        return status;
    endfunction

    // Stops offering words and waits until every status word is back.
    // Must run in the step that follows the last accepted word, or later.
    task automatic wait_pattern_drained();
        i_s_tvalid <= 1'b0;
        while (led_word_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Offers one tick word after a random gap and records the expected answer
    // when it is taken. The valid is left high so back-to-back words need no
    // second assignment in the same step.
    task automatic send_tick(input logic tick_bit, input logic typed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(tick_bit);
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predicted = advance_pattern(tick_bit);
        led_word_q.push_back(typed ? want : predicted);
        ticks_sent++;
        if (!tick_bit)
            idle_ticks++;
    endtask

    // Writes one register with the pattern drained, and mirrors it in the shadow.
    task automatic write_pattern_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
        wait_pattern_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_STEP_TIME_0, REG_STEP_TIME_1, REG_STEP_TIME_2, REG_STEP_TIME_3: begin
                pattern_cfg.step_time[idx[POS_W-1:0]] = value[STEP_TIME_W-1:0];
            end
            REG_STEP_COUNT: begin
                pattern_cfg.step_count = value[STEP_CNT_W-1:0];
            end
            REG_REPEAT: begin
                // Writing the repeat register also restarts the remaining count.
                repeats_left = value[REPEAT_W-1:0];
            end
            REG_TICK_MS: begin
                pattern_cfg.tick_ms = value[TICK_MS_W-1:0];
            end
            default: begin
                // Outside the register file: dropped.
            end
        endcase
        reg_writes++;
        // A further wait on the clock keeps the write enable from being raised again in
        // the step where it was just lowered.
        @(posedge i_clk);
    endtask

    // Receiver: checks each status word taken against the oldest expectation,
    // then picks the ready for the next cycle. A long hold-off, when asked
    // for, keeps ready low until the hold_left counter loaded from hold_req runs out.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_word = t_result'(o_m_tdata[2:0]);
            words_checked++;
            if (got_word.finished)
                finished_seen++;
            if (led_word_q.size() == 0) begin
                $error("status word %h arrived with none expected", o_m_tdata);
                mismatches++;
            end else begin
                want_word = led_word_q.pop_front();
                if (got_word.led_on !== want_word.led_on) begin
                    $error("led_on: expected %0b, got %0b", want_word.led_on, got_word.led_on);
                    mismatches++;
                end
                if (got_word.finished !== want_word.finished) begin
                    $error("finished: expected %0b, got %0b",
                           want_word.finished, got_word.finished);
                    mismatches++;
                end
                if (got_word.running !== want_word.running) begin
                    $error("running: expected %0b, got %0b",
                           want_word.running, got_word.running);
                    mismatches++;
                end
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int r;
        int phase;
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with light idling on both sides.
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_pattern_reg(directed_rows[r].reg_idx, directed_rows[r].value);
            else
                send_tick(directed_rows[r].value[0], directed_rows[r].typed,
                          directed_rows[r].want);
        end

        // Random part: short phases, each with a fresh setting, so that the
        // repeat count is reloaded often and the finished flag keeps coming.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase

            if (phase == 0) begin
                // Upper extremes everywhere.
                for (r = 0; r < TIME_REGS; r++)
                    write_pattern_reg(t_cfg_reg'(REG_STEP_TIME_0 + r), 16'hFFFF);
                write_pattern_reg(REG_STEP_COUNT, 16'(EFF_LIMIT));
                write_pattern_reg(REG_TICK_MS, 16'd1000);
                write_pattern_reg(REG_REPEAT, 16'h7FFF);
            end else if (phase == 1) begin
                // Lower extremes: empty steps and a disabled pattern.
                for (r = 0; r < TIME_REGS; r++)
                    write_pattern_reg(t_cfg_reg'(REG_STEP_TIME_0 + r), 16'd0);
                write_pattern_reg(REG_STEP_COUNT, 16'd0);
                write_pattern_reg(REG_TICK_MS, 16'd1);
                write_pattern_reg(REG_REPEAT, 16'hFFFF);
            end else begin
                // Mostly short steps so whole passes fit in a phase; now and
                // then a long or maximal one.
                for (r = 0; r < TIME_REGS; r++) begin
                    if ($urandom_range(9) < 6) begin
                        n = $urandom_range(9);
                        write_pattern_reg(t_cfg_reg'(REG_STEP_TIME_0 + r),
                                          (n < 8) ? 16'($urandom_range(6)) :
                                          (n == 8) ? 16'($urandom_range(65535)) : 16'hFFFF);
                    end
                end
                if ($urandom_range(9) < 6) begin
                    n = $urandom_range(99);
                    write_pattern_reg(REG_STEP_COUNT,
                                      (n < 85) ? 16'($urandom_range(1, EFF_LIMIT)) :
                                                 16'($urandom_range(7)));
                end
                if ($urandom_range(9) < 6) begin
                    n = $urandom_range(9);
                    write_pattern_reg(REG_TICK_MS,
                                      (n < 7) ? 16'd1 :
                                      (n < 9) ? 16'($urandom_range(1, 3)) :
                                                16'($urandom_range(1, 1000)));
                end
                n = $urandom_range(99);
                write_pattern_reg(REG_REPEAT,
                                  (n < 60) ? 16'($urandom_range(1, 3)) :
                                  (n < 75) ? 16'hFFFF :
                                  (n < 85) ? 16'd0 : 16'($urandom_range(32767)));
            end

            // One phase lets the output side hold off for a long stretch while
            // words keep coming, so the block fills up and stops taking input.
            if (phase == 6) begin
                send_idle_pct = 0;
                hold_req      = HOLD_CYCLES;
            end

            for (n = 0; n < WORDS_PER_PHASE; n++)
                send_tick($urandom_range(9) != 0, 1'b0, '0);
        end

        // Let everything come back, then give a stray word time to show up.
        wait_pattern_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (led_word_q.size() != 0) begin
            $error("%0d status words never arrived", led_word_q.size());
            mismatches++;
        end

        $display("Run covered %0d tick words (%0d with the tick flag clear) and %0d register writes,",
                 ticks_sent, idle_ticks, reg_writes);
        $display("with %0d status words checked and %0d finished flags seen.",
                 words_checked, finished_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
